// File: sv/pif_pkg.sv
// ============================================================================
// pif_pkg: shared types and constants of the printf integer formatter
// Job descriptor passed from the front to the back, character codes and
// digit tables.
// ============================================================================
package pif_pkg;

    // character codes
    localparam logic [7:0] CH_PCT   = 8'h25;  // '%'
    localparam logic [7:0] CH_MINUS = 8'h2d;  // '-'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_LX    = 8'h78;  // 'x'
    localparam logic [7:0] CH_UX    = 8'h58;  // 'X'
    localparam logic [7:0] CH_LC    = 8'h63;  // 'c'
    localparam logic [7:0] CH_LD    = 8'h64;  // 'd'
    localparam logic [7:0] CH_LI    = 8'h69;  // 'i'
    localparam logic [7:0] CH_LU    = 8'h75;  // 'u'
    localparam logic [7:0] CH_LP    = 8'h70;  // 'p'
    localparam logic [7:0] CH_LA    = 8'h61;  // 'a'
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    localparam logic [7:0] HEX_DIGITS [16] = '{
        "0", "1", "2", "3", "4", "5", "6", "7",
        "8", "9", "a", "b", "c", "d", "e", "f"
    };

    // digit position of the most significant digit
    localparam logic [3:0] DEC_TOP   = 4'd9;
    localparam logic [3:0] HEX32_TOP = 4'd7;
    localparam logic [3:0] PTR_TOP   = 4'd15;

    localparam logic [30:0] COUNT_MAX = 31'h7fff_ffff;

    typedef enum logic [1:0] {
        JK_CHAR,
        JK_DEC,
        JK_HEX
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic        neg;    // emit '-' before the digits
        logic        ptr;    // emit "0x" and all 64 bits
        logic        upper;  // upper-case hex letters
        logic        clr;    // restart the character count
        logic [63:0] value;
    } t_job;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_CHAR,
        BS_SIGN,
        BS_P0,
        BS_PX,
        BS_DIGIT
    } t_back_state;

    function automatic logic [33:0] pow10(input logic [3:0] k);
        logic [33:0] p;
        case (k)
            4'd0:    p = 34'd1;
            4'd1:    p = 34'd10;
            4'd2:    p = 34'd100;
            4'd3:    p = 34'd1000;
            4'd4:    p = 34'd10000;
            4'd5:    p = 34'd100000;
            4'd6:    p = 34'd1000000;
            4'd7:    p = 34'd10000000;
            4'd8:    p = 34'd100000000;
            4'd9:    p = 34'd1000000000;
            default: p = '0;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        c = HEX_DIGITS[d];
        if (upper && c >= CH_LA) begin
            c = c - CASE_OFFSET;
        end
        return c;
    endfunction

endpackage

// File: sv/printf_integer_formatter.sv
// ============================================================================
// printf_integer_formatter: printf-style integer formatter
// Expands format characters and their arguments into a character stream.
// ============================================================================
// usage
//   input side is a queue: drive a format character, its argument and the
//   format_start flag, raise push; the beat is taken when full is low
//   output side is a queue: while empty is low the oldest character is on
//   o_out_char with o_last_of_run and o_count_so_far; pop takes it
//   ordinary characters echo, '%' waits for the next character, which picks
//   %c %d %i %u %x %X %p or %%; other directives produce nothing
// timing
//   the back end takes a job from the job queue, then works through it step
//   by step: a single character (echo, %c, %%); an optional '-' and every
//   decimal digit (%d/%i/%u); every nibble of the 32-bit value (%x/%X); "0x"
//   and every nibble of 64 bits (%p); zero digits ahead of the first
//   significant one use a step but give no beat; the digit loop (one decimal
//   compare-and-subtract or one nibble a cycle unless the output stalls)
//   sets the rate; the job queue lets the input keep accepting meanwhile
// reset and stall
//   reset empties the queues, drops a pending '%' and zeroes the count
//   a stalled receiver holds the current character; the back end waits and
//   the input stays open until the job queue fills
// ============================================================================
module printf_integer_formatter #(
    parameter int JOBQ_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_format_char,
    input  logic [63:0] i_argument_value,
    input  logic        i_format_start,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_char,
    output logic        o_last_of_run,
    output logic [30:0] o_count_so_far
);
    import pif_pkg::*;

    t_job job_in;      // job leaving the front
    t_job job_out;     // oldest queued job
    logic job_push;
    logic q_full, q_empty, q_pop;

    // front: pending '%' and directive decode
    pif_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .i_format_char    (i_format_char),
        .i_argument_value (i_argument_value),
        .i_format_start   (i_format_start),
        .i_q_full         (q_full),
        .o_job_push       (job_push),
        .o_job            (job_in)
    );

    // decouples classification from character generation
    pif_jobq #(
        .DEPTH (JOBQ_DEPTH)
    ) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .i_pop   (q_pop),
        .o_job   (job_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // back: digit generation, count and output register
    pif_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job          (job_out),
        .i_q_empty      (q_empty),
        .o_q_pop        (q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_out_char     (o_out_char),
        .o_last_of_run  (o_last_of_run),
        .o_count_so_far (o_count_so_far)
    );

    // input stalls only when the job queue is full
    assign full = q_full;

endmodule

// File: sv/pif_front.sv
// ============================================================================
// pif_front: format character classifier
// Tracks a pending '%', decodes directives and issues one job per item
// that produces characters.
// ============================================================================
module pif_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [7:0]    i_format_char,
    input  logic [63:0]   i_argument_value,
    input  logic          i_format_start,
    input  logic          i_q_full,
    output logic          o_job_push,
    output pif_pkg::t_job o_job
);
    import pif_pkg::*;

    logic        r_pending, n_pending;
    logic        r_clr, n_clr;     // restart seen, not yet passed on in a job
    logic        accept;
    logic        pend_eff;
    logic        emits;
    logic [31:0] w;
    logic [31:0] mag;

    assign accept   = i_push && !i_q_full;
    assign pend_eff = r_pending && !i_format_start;
    assign w        = i_argument_value[31:0];
    assign mag      = w[31] ? (32'd0 - w) : w;

    always_comb begin
        emits       = 1'b0;
        n_pending   = 1'b0;
        o_job.kind  = JK_CHAR;
        o_job.neg   = 1'b0;
        o_job.ptr   = 1'b0;
        o_job.upper = 1'b0;
        o_job.clr   = r_clr || i_format_start;
        o_job.value = {56'd0, i_format_char};
        if (pend_eff) begin
            case (i_format_char)
                CH_LC: begin
                    emits       = 1'b1;
                    o_job.value = {56'd0, i_argument_value[7:0]};
                end
                CH_LD, CH_LI: begin
                    emits       = 1'b1;
                    o_job.kind  = JK_DEC;
                    o_job.neg   = w[31];
                    o_job.value = {32'd0, mag};
                end
                CH_LU: begin
                    emits       = 1'b1;
                    o_job.kind  = JK_DEC;
                    o_job.value = {32'd0, w};
                end
                CH_LX, CH_UX: begin
                    emits       = 1'b1;
                    o_job.kind  = JK_HEX;
                    o_job.upper = (i_format_char == CH_UX);
                    o_job.value = {w, 32'd0};
                end
                CH_LP: begin
                    emits       = 1'b1;
                    o_job.kind  = JK_HEX;
                    o_job.ptr   = 1'b1;
                    o_job.value = i_argument_value;
                end
                CH_PCT: begin
                    emits       = 1'b1;
                    o_job.value = {56'd0, CH_PCT};
                end
                default: begin
                    emits = 1'b0;
                end
            endcase
        end else if (i_format_char == CH_PCT) begin
            n_pending = 1'b1;
        end else begin
            emits = 1'b1;
        end
    end

    assign o_job_push = accept && emits;
    assign n_clr      = emits ? 1'b0 : (r_clr || i_format_start);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_clr     <= 1'b0;
        end else if (accept) begin
            r_pending <= n_pending;
            r_clr     <= n_clr;
        end
    end

endmodule

// File: sv/pif_jobq.sv
// ============================================================================
// pif_jobq: job queue between front and back
// Small first-in first-out store of job descriptors.
// ============================================================================
module pif_jobq #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pif_pkg::t_job i_job,
    input  logic          i_pop,
    output pif_pkg::t_job o_job,
    output logic          o_full,
    output logic          o_empty
);
    import pif_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd];

    assign n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= n_wr;
            end
            if (do_pop) begin
                r_rd <= n_rd;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: sv/pif_back.sv
// ============================================================================
// pif_back: character generator
// Turns one job into characters, one digit per step, most significant
// first with leading zeros dropped; keeps the running count.
// ============================================================================
module pif_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pif_pkg::t_job i_job,
    input  logic          i_q_empty,
    output logic          o_q_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [7:0]    o_out_char,
    output logic          o_last_of_run,
    output logic [30:0]   o_count_so_far
);
    import pif_pkg::*;

    t_back_state r_state, n_state;
    logic        r_dec, r_upper;
    logic [63:0] r_val, n_val;
    logic [3:0]  r_pos, n_pos;
    logic        r_started, n_started;
    logic [33:0] r_mult [10];
    logic [33:0] n_mult [10];
    logic [30:0] r_count, n_count;
    logic        r_out_valid;
    logic [7:0]  r_out_char;
    logic        r_out_last;
    logic [30:0] r_out_count;

    logic        adv;
    logic        emit, e_last, step;
    logic [7:0]  e_char;
    logic [3:0]  dec_d, dig;
    logic [31:0] dec_rem;
    logic [3:0]  load_pos;
    logic [30:0] count_base, count_inc;

    // output slot frees when empty or being taken
    assign adv = !r_out_valid || i_pop;

    // decimal digit: largest multiple of the power of ten not above the value
    always_comb begin
        dec_d = 4'd0;
        for (int m = 1; m < 10; m++) begin
            if ({2'b00, r_val[31:0]} >= r_mult[m]) begin
                dec_d = 4'(m);
            end
        end
    end

    assign dec_rem = 32'({2'b00, r_val[31:0]} - r_mult[dec_d]);
    assign dig     = r_dec ? dec_d : r_val[63:60];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_IDLE: begin
                if (!i_q_empty) begin
                    if (i_job.kind == JK_CHAR) begin
                        n_state = BS_CHAR;
                    end else if (i_job.neg) begin
                        n_state = BS_SIGN;
                    end else if (i_job.ptr) begin
                        n_state = BS_P0;
                    end else begin
                        n_state = BS_DIGIT;
                    end
                end
            end
            BS_CHAR: begin
                if (adv) begin
                    n_state = BS_IDLE;
                end
            end
            BS_SIGN: begin
                if (adv) begin
                    n_state = BS_DIGIT;
                end
            end
            BS_P0: begin
                if (adv) begin
                    n_state = BS_PX;
                end
            end
            BS_PX: begin
                if (adv) begin
                    n_state = BS_DIGIT;
                end
            end
            BS_DIGIT: begin
                if (adv && r_pos == 4'd0) begin
                    n_state = BS_IDLE;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_q_pop = 1'b0;
        emit    = 1'b0;
        e_char  = r_val[7:0];
        e_last  = 1'b0;
        step    = 1'b0;
        case (r_state)
            BS_IDLE: begin
                o_q_pop = !i_q_empty;
            end
            BS_CHAR: begin
                emit   = adv;
                e_last = 1'b1;
            end
            BS_SIGN: begin
                emit   = adv;
                e_char = CH_MINUS;
            end
            BS_P0: begin
                emit   = adv;
                e_char = CH_ZERO;
            end
            BS_PX: begin
                emit   = adv;
                e_char = CH_LX;
            end
            BS_DIGIT: begin
                step   = adv;
                emit   = adv && (r_started || dig != 4'd0 || r_pos == 4'd0);
                e_char = digit_char(dig, r_upper);
                e_last = (r_pos == 4'd0);
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb begin
        if (i_job.kind == JK_DEC) begin
            load_pos = DEC_TOP;
        end else if (i_job.ptr) begin
            load_pos = PTR_TOP;
        end else begin
            load_pos = HEX32_TOP;
        end

        n_val     = r_val;
        n_pos     = r_pos;
        n_started = r_started;
        if (o_q_pop) begin
            n_val     = i_job.value;
            n_pos     = load_pos;
            n_started = 1'b0;
        end else if (step) begin
            n_val     = r_dec ? {32'd0, dec_rem} : {r_val[59:0], 4'd0};
            n_pos     = r_pos - 1'b1;
            n_started = r_started || (dig != 4'd0);
        end

        // multiples of the power of ten for the coming digit
        for (int m = 0; m < 10; m++) begin
            n_mult[m] = 34'(pow10(n_pos) * 34'(m));
        end

        count_base = (o_q_pop && i_job.clr) ? 31'd0 : r_count;
        count_inc  = (r_count == COUNT_MAX) ? r_count : r_count + 31'd1;
        n_count    = emit ? count_inc : count_base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (adv) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_dec   <= (i_job.kind == JK_DEC);
            r_upper <= i_job.upper;
        end
        r_val     <= n_val;
        r_pos     <= n_pos;
        r_started <= n_started;
        r_mult    <= n_mult;
        if (adv) begin
            r_out_char  <= e_char;
            r_out_last  <= e_last;
            r_out_count <= count_inc;
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_out_char     = r_out_char;
    assign o_last_of_run  = r_out_last;
    assign o_count_so_far = r_out_count;

endmodule

// File: sv/pif_checker.sv
// ============================================================================
// pif_checker: port-level checks of the printf integer formatter
// Watches both queue sides and the count carried by the output beats.
// ============================================================================
module pif_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [7:0]  o_out_char,
    input logic        o_last_of_run,
    input logic [30:0] o_count_so_far
);
    import pif_pkg::*;

    // after reset both queues are empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    // a waiting beat holds while the receiver stalls
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_out_char) && $stable(o_last_of_run)
            && $stable(o_count_so_far))
        else $error("output beat changed while stalled");

    // every beat counts itself
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_count_so_far != 31'd0)
        else $error("beat with zero count");

    // within a run the count steps by one from beat to beat
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !empty && !o_last_of_run && o_count_so_far != COUNT_MAX
        |=> empty || o_count_so_far == $past(o_count_so_far) + 31'd1)
        else $error("count did not advance within a run");

endmodule

bind printf_integer_formatter pif_checker u_pif_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .full           (full),
    .empty          (empty),
    .pop            (pop),
    .o_out_char     (o_out_char),
    .o_last_of_run  (o_last_of_run),
    .o_count_so_far (o_count_so_far)
);

// File: verif/printf_integer_formatter_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// printf_integer_formatter_tb: self-checking bench for the printf formatter
// Drives format characters with arguments through the input queue and checks
// every emitted character, its end-of-run flag and the running count against
// a behavioral predictor, with random sender gaps and receiver stalls.
// ============================================================================
module printf_integer_formatter_tb;
    import pif_pkg::*;

    // characters that only this bench needs
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_LS  = 8'h73;  // 's', not supported
    localparam logic [7:0] CH_LQ  = 8'h71;  // 'q', never a directive

    localparam logic [7:0] DIRECTIVE_CODES [8] = '{
        CH_LC, CH_LD, CH_LI, CH_LU, CH_LX, CH_UX, CH_LP, CH_PCT
    };

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [7:0]  ch;
        logic        last;
        logic [30:0] count;
    } t_emitted_char;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        pop = 1'b0;
    logic [7:0]  i_format_char = '0;
    logic [63:0] i_argument_value = '0;
    logic        i_format_start = 1'b0;
    logic        full;
    logic        empty;
    logic [7:0]  o_out_char;
    logic        o_last_of_run;
    logic [30:0] o_count_so_far;

    // predictor state, updated at each accepted input beat
    logic        fmt_pending = 1'b0;
    logic [30:0] fmt_count = '0;
    logic [7:0]  run_chars[$];
    t_emitted_char expected_chars[$];

    int idle_pct = 0;    // chance in 100 that the sender skips a cycle
    int stall_pct = 0;   // chance in 100 that the receiver holds off
    int beats_sent = 0;
    int fault_count = 0;
    int cycle_count = 0;

    printf_integer_formatter dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_format_char    (i_format_char),
        .i_argument_value (i_argument_value),
        .i_format_start   (i_format_start),
        .empty            (empty),
        .pop              (pop),
        .o_out_char       (o_out_char),
        .o_last_of_run    (o_last_of_run),
        .o_count_so_far   (o_count_so_far)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // digits of v in base 10 or 16, most significant first, no leading zeros
    task automatic append_number(input logic [63:0] v, input int unsigned base,
                                 input logic upper);
        logic [7:0]  digits[$];
        logic [63:0] rest;
        logic [63:0] d;
        rest = v;
        do begin
            d = rest % base;
            if (d < 10) begin
                digits.push_front(CH_ZERO + d[7:0]);
            end else if (upper) begin
                digits.push_front(CH_LA - CASE_OFFSET + d[7:0] - 8'd10);
            end else begin
                digits.push_front(CH_LA + d[7:0] - 8'd10);
            end
            rest = rest / base;
        end while (rest != 0);
        foreach (digits[k]) run_chars.push_back(digits[k]);
    endtask

    // works out the characters one accepted beat causes and queues them
    task automatic predict_beat(input logic [7:0] ch, input logic [63:0] arg,
                                input logic start);
        logic [31:0] word;
        if (start) begin
            fmt_count = '0;
            fmt_pending = 1'b0;
        end
        run_chars.delete();
        word = arg[31:0];
        if (fmt_pending) begin
            fmt_pending = 1'b0;
            case (ch)
                CH_LC: run_chars.push_back(arg[7:0]);
                CH_LD, CH_LI: begin
                    // most negative value: negating wraps to its own magnitude
                    if (word[31]) begin
                        run_chars.push_back(CH_MINUS);
                        word = -word;
                    end
                    append_number({32'd0, word}, 10, 1'b0);
                end
                CH_LU: append_number({32'd0, word}, 10, 1'b0);
                CH_LX: append_number({32'd0, word}, 16, 1'b0);
                CH_UX: append_number({32'd0, word}, 16, 1'b1);
                CH_LP: begin
                    run_chars.push_back(CH_ZERO);
                    run_chars.push_back(CH_LX);
                    append_number(arg, 16, 1'b0);
                end
                CH_PCT: run_chars.push_back(CH_PCT);
                default: ;  // unknown directive gives nothing
            endcase
        end else if (ch == CH_PCT) begin
            fmt_pending = 1'b1;
        end else begin
            run_chars.push_back(ch);  // NUL echoes too
        end
        foreach (run_chars[k]) begin
            t_emitted_char e;
            if (fmt_count != COUNT_MAX) fmt_count = fmt_count + 31'd1;
            e.ch = run_chars[k];
            e.last = (k == run_chars.size() - 1);
            e.count = fmt_count;
            expected_chars.push_back(e);
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // one input beat; called right after a rising edge, returns at acceptance
    task automatic send_beat(input logic [7:0] ch, input logic [63:0] arg,
                             input logic start);
        // random sender gaps, push stays high when no gap is taken
        while ($urandom_range(0, 99) < idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_format_char <= ch;
        i_argument_value <= arg;
        i_format_start <= start;
        do @(posedge i_clk); while (full);
        predict_beat(ch, arg, start);
        beats_sent++;
    endtask

    // '%' beat with a junk argument, then the directive beat
    task automatic send_directive(input logic [7:0] code, input logic [63:0] arg);
        send_beat(CH_PCT, {$urandom, $urandom}, 1'b0);
        send_beat(code, arg, 1'b0);
    endtask

    // argument values biased toward zero, short numbers, sign and all ones
    function automatic logic [63:0] random_argument();
        logic [63:0] v;
        case ($urandom_range(0, 6))
            0: v = '0;
            1: v = 64'($urandom_range(0, 9));
            2: v = {32'($urandom), 32'h8000_0000};
            3: v = '1;
            4: v = {32'($urandom), 32'($urandom)} >> $urandom_range(0, 63);
            default: v = {32'($urandom), 32'($urandom)};
        endcase
        return v;
    endfunction

    function automatic logic [7:0] random_plain_char();
        logic [7:0] ch;
        do ch = 8'($urandom_range(0, 255)); while (ch == CH_PCT);
        return ch;
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // ordinary characters echo, NUL and 8'hff included, %% gives one '%'
    task automatic test_plain_text();
        send_beat(8'h48, '1, 1'b1);
        send_beat(CH_NUL, '0, 1'b0);
        send_beat(8'hff, '0, 1'b0);
        send_directive(CH_PCT, '1);
    endtask

    // %c takes only the low byte
    task automatic test_char_directive();
        send_directive(CH_LC, 64'hffff_ffff_ffff_ff41);
    endtask

    // most negative value and zero on the signed path
    task automatic test_signed_decimal();
        send_directive(CH_LD, 64'hffff_ffff_8000_0000);
        send_directive(CH_LI, 64'hffff_ffff_0000_0000);
    endtask

    task automatic test_unsigned_decimal();
        send_directive(CH_LU, 64'h0000_0000_ffff_ffff);
    endtask

    task automatic test_hex();
        send_directive(CH_LX, 64'hffff_ffff_0000_0000);
        send_directive(CH_UX, 64'h0000_0000_abcd_ef12);
    endtask

    // %p: longest run (18 characters) and the "0x0" zero case
    task automatic test_pointer();
        send_directive(CH_LP, '1);
        send_directive(CH_LP, '0);
    endtask

    // unsupported and NUL directives are swallowed
    task automatic test_unknown_directive();
        send_directive(CH_LS, '1);
        send_directive(CH_NUL, '1);
    endtask

    // a new format drops a pending '%' and restarts the count
    task automatic test_format_restart();
        send_beat(CH_PCT, '0, 1'b0);
        send_beat(CH_LX, '1, 1'b1);
        send_beat(CH_LQ, '0, 1'b0);
    endtask

    // mostly well-formed directive traffic with noise and broken sequences
    task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
                                       input int n_beats);
        int stop_at;
        int pick;
        idle_pct = sender_idle;
        stall_pct = receiver_stall;
        stop_at = beats_sent + n_beats;
        while (beats_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                send_beat(random_plain_char(), {$urandom, $urandom}, 1'b0);
            end else if (pick < 80) begin
                send_directive(DIRECTIVE_CODES[$urandom_range(0, 7)], random_argument());
            end else if (pick < 88) begin
                // any byte as directive, mostly unknown ones
                send_directive(8'($urandom_range(0, 255)), {$urandom, $urandom});
            end else if (pick < 94) begin
                send_beat(8'($urandom_range(0, 255)), {$urandom, $urandom}, 1'b1);
            end else begin
                // broken sequence: '%' left pending across a format start
                send_beat(CH_PCT, {$urandom, $urandom}, 1'b0);
                send_beat(random_plain_char(), random_argument(), 1'b1);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // receiver and checker
    // ------------------------------------------------------------------------

    always @(posedge i_clk) begin
        pop <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin : check_output
        t_emitted_char want;
        if (i_rst_n && pop && !empty) begin
            if (expected_chars.size() == 0) begin
                if (fault_count < MAX_REPORTS) begin
                    $display("unexpected beat: char %h last %b count %0d",
                             o_out_char, o_last_of_run, o_count_so_far);
                end
                fault_count++;
            end else begin
                want = expected_chars.pop_front();
                if (o_out_char !== want.ch || o_last_of_run !== want.last ||
                    o_count_so_far !== want.count) begin
                    if (fault_count < MAX_REPORTS) begin
                        $display("wrong beat: expected char %h last %b count %0d, got %h %b %0d",
                                 want.ch, want.last, want.count,
                                 o_out_char, o_last_of_run, o_count_so_far);
                    end
                    fault_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("printf_integer_formatter: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, no idling
        test_plain_text();
        test_char_directive();
        test_signed_decimal();
        test_unsigned_decimal();
        test_hex();
        test_pointer();
        test_unknown_directive();
        test_format_restart();

        // random part, one idling mix per phase
        test_random_traffic(0, 0, 31);
        test_random_traffic(48, 0, 31);
        test_random_traffic(0, 48, 31);
        test_random_traffic(17, 17, 31);

        // drain with the receiver always ready, then watch for strays
        push <= 1'b0;
        stall_pct = 0;
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fault_count == 0) begin
            $display("printf_integer_formatter: match");
        end else begin
            $display("printf_integer_formatter: mismatch");
        end
        $finish;
    end

endmodule

// File: files.f
sv/pif_pkg.sv
sv/pif_front.sv
sv/pif_jobq.sv
sv/pif_back.sv
sv/printf_integer_formatter.sv
sv/pif_checker.sv
verif/printf_integer_formatter_tb.sv
